>>> rtl/rgb_to_hsv_converter_core_defines.svh
// assertion macros for the rgb to hsv converter
// expect clk and arst_n in the scope of the module that uses them
`ifndef RGB_TO_HSV_CONVERTER_CORE_DEFINES_SVH
`define RGB_TO_HSV_CONVERTER_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define RGBHSV_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define RGBHSV_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/rgbhsv_pkg.sv
// types and constants for the rgb to hsv converter
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rgbhsv_pkg;

	localparam int CHAN_W    = 8;
	localparam int HUE_W     = 13;
	localparam int HQ_W      = 10;
	localparam int HNUM_W    = 18;
	localparam int SQ_W      = 8;
	localparam int SNUM_W    = 16;
	localparam int DIV_STEPS = 10;

	localparam logic [HUE_W-1:0] HUE_SIXTY = 13'd960;
	localparam logic [HUE_W-1:0] HUE_GREEN = 13'(2 * 960);
	localparam logic [HUE_W-1:0] HUE_BLUE  = 13'(4 * 960);
	localparam logic [HUE_W-1:0] HUE_FULL  = 13'd5760;

	typedef logic [CHAN_W-1:0] chan_t;
	typedef logic [HUE_W-1:0]  hue_t;

	typedef enum logic [1:0] {
		SEC_RED,
		SEC_GREEN,
		SEC_BLUE
	} sector_t;

	typedef struct packed {
		chan_t   mx;
		chan_t   delta;
		sector_t sector;
		logic    neg;
		chan_t   absdiff;
	} prep_t;

	typedef struct packed {
		chan_t              mx;
		chan_t              delta;
		sector_t            sector;
		logic               neg;
		logic [HNUM_W-1:0]  hrem;
		logic [HQ_W-1:0]    hq;
		logic [SNUM_W-1:0]  srem;
		logic [SQ_W-1:0]    sq;
	} divst_t;

endpackage

`default_nettype wire

>>> rtl/rgb_to_hsv_converter_core.sv
// 13 register stages: prep_s1, div_s[0] to div_s[10], then the output registers
// one pixel per cycle while hsv_stall is low; ten-step pipelined restoring divider
// each stage moves on when its successor frees up, so bubbles close up under stall
// reset: arst_n clears all valid bits asynchronously, payload registers are not reset
// depends on rgbhsv_pkg and rgb_to_hsv_converter_core_defines.svh
`timescale 1ns / 1ps
`default_nettype none
`include "rgb_to_hsv_converter_core_defines.svh"

module rgb_to_hsv_converter_core (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                rgb_valid,
	output logic                     rgb_stall,
	input  wire rgbhsv_pkg::chan_t   red,
	input  wire rgbhsv_pkg::chan_t   green,
	input  wire rgbhsv_pkg::chan_t   blue,
	output logic                     hsv_valid,
	input  wire logic                hsv_stall,
	output rgbhsv_pkg::hue_t         hue,
	output rgbhsv_pkg::chan_t        saturation,
	output rgbhsv_pkg::chan_t        value
);
	import rgbhsv_pkg::*;

	localparam int NS = DIV_STEPS + 3;

	logic [NS-1:0] vld_s;
	logic [NS:0]   ready;

	prep_t  prep_nxt;
	prep_t  prep_s1;
	divst_t num_nxt;
	divst_t div_s [DIV_STEPS+1];
	divst_t div_nxt [DIV_STEPS];
	divst_t fin;
	hue_t   hue_nxt;
	chan_t  sat_nxt;
	hue_t   q13;
	hue_t   hue_s13;
	chan_t  sat_s13;
	chan_t  val_s13;

	// per-stage flow control
	always_comb begin
		ready[NS] = !hsv_stall;
		for (int i = NS - 1; i >= 0; i--) begin
			ready[i] = !vld_s[i] || ready[i+1];
		end
	end

	assign rgb_stall = !ready[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (ready[0]) begin
				vld_s[0] <= rgb_valid;
			end
			for (int i = 1; i < NS; i++) begin
				if (ready[i]) begin
					vld_s[i] <= vld_s[i-1];
				end
			end
		end
	end

	// stage 1: max, min, sector and signed difference
	always_comb begin
		chan_t mn;
		prep_nxt.mx = red;
		mn          = red;
		if (green > prep_nxt.mx) prep_nxt.mx = green;
		if (blue > prep_nxt.mx)  prep_nxt.mx = blue;
		if (green < mn) mn = green;
		if (blue < mn)  mn = blue;
		prep_nxt.delta = prep_nxt.mx - mn;
		if (red == prep_nxt.mx) begin
			prep_nxt.sector  = SEC_RED;
			prep_nxt.neg     = green < blue;
			prep_nxt.absdiff = (green < blue) ? blue - green : green - blue;
		end else if (green == prep_nxt.mx) begin
			prep_nxt.sector  = SEC_GREEN;
			prep_nxt.neg     = blue < red;
			prep_nxt.absdiff = (blue < red) ? red - blue : blue - red;
		end else begin
			prep_nxt.sector  = SEC_BLUE;
			prep_nxt.neg     = red < green;
			prep_nxt.absdiff = (red < green) ? green - red : red - green;
		end
	end

	always_ff @(posedge clk) begin
		if (ready[0]) begin
			prep_s1 <= prep_nxt;
		end
	end

	// stage 2: scaled numerators, delta*255 and |diff|*960
	always_comb begin
		num_nxt.mx     = prep_s1.mx;
		num_nxt.delta  = prep_s1.delta;
		num_nxt.sector = prep_s1.sector;
		num_nxt.neg    = prep_s1.neg;
		num_nxt.hrem   = (HNUM_W'(prep_s1.absdiff) << 10) - (HNUM_W'(prep_s1.absdiff) << 6);
		num_nxt.hq     = '0;
		num_nxt.srem   = (SNUM_W'(prep_s1.delta) << 8) - SNUM_W'(prep_s1.delta);
		num_nxt.sq     = '0;
	end

	always_ff @(posedge clk) begin
		if (ready[1]) begin
			div_s[0] <= num_nxt;
		end
	end

	// restoring division, msb first; hue bit per stage, saturation bit where K < SQ_W
	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
		localparam int K = DIV_STEPS - 1 - j;

		always_comb begin
			logic [HNUM_W-1:0] hd;
			logic [SNUM_W-1:0] sd;
			div_nxt[j] = div_s[j];
			hd = HNUM_W'(div_s[j].delta) << K;
			sd = SNUM_W'(div_s[j].mx) << K;
			if (div_s[j].hrem >= hd) begin
				div_nxt[j].hrem  = div_s[j].hrem - hd;
				div_nxt[j].hq[K] = 1'b1;
			end
			if (K < SQ_W) begin
				if (div_s[j].srem >= sd) begin
					div_nxt[j].srem = div_s[j].srem - sd;
					div_nxt[j].sq   = div_s[j].sq | SQ_W'(1 << K);
				end
			end
		end

		always_ff @(posedge clk) begin
			if (ready[j+2]) begin
				div_s[j+1] <= div_nxt[j];
			end
		end
	end

	// output stage: sector offset, sign and wrap, grey pixels
	assign fin = div_s[DIV_STEPS];
	assign q13 = HUE_W'(fin.hq);

	always_comb begin
		hue_t base;
		case (fin.sector)
			SEC_RED:   base = '0;
			SEC_GREEN: base = HUE_GREEN;
			SEC_BLUE:  base = HUE_BLUE;
			default:   base = '0;
		endcase
		sat_nxt = fin.sq;
		if (fin.delta == '0) begin
			hue_nxt = '0;
			sat_nxt = '0;
		end else if (!fin.neg) begin
			hue_nxt = base + q13;
		end else if (fin.sector == SEC_RED) begin
			hue_nxt = (q13 == '0) ? '0 : HUE_FULL - q13;
		end else begin
			hue_nxt = base - q13;
		end
	end

	always_ff @(posedge clk) begin
		if (ready[NS-1]) begin
			hue_s13 <= hue_nxt;
			sat_s13 <= sat_nxt;
			val_s13 <= fin.mx;
		end
	end

	assign hsv_valid  = vld_s[NS-1];
	assign hue        = hue_s13;
	assign saturation = sat_s13;
	assign value      = val_s13;

	`RGBHSV_ASSERT_NOW(a_hue_range, hsv_valid, hue < HUE_FULL, "hue out of range")
	`RGBHSV_ASSERT_NOW(a_black_grey, hsv_valid && value == '0,
		hue == '0 && saturation == '0, "black pixel with nonzero hue or saturation")
	`RGBHSV_ASSERT_NOW(a_grey_hue, hsv_valid && saturation == '0, hue == '0,
		"unsaturated pixel with nonzero hue")
	`RGBHSV_ASSERT_NOW(a_stall_full, rgb_stall, hsv_valid && hsv_stall && (&vld_s),
		"request stalled while pipeline has room")
	`RGBHSV_ASSERT_NEXT(a_out_hold, hsv_valid && hsv_stall,
		hsv_valid && $stable(hue) && $stable(saturation) && $stable(value),
		"stalled result changed")

endmodule

`default_nettype wire

>>> dv/tb_rgb_to_hsv_converter_core.sv
// self-checking testbench for rgb_to_hsv_converter_core: directed pixel table, then random pixels
// every result checked against typed values or an integer hsv predictor, with random idling and a long sink hold-off
// depends on rgbhsv_pkg and the rgb_to_hsv_converter_core rtl
`timescale 1ns / 1ps

module tb_rgb_to_hsv_converter_core;

	import rgbhsv_pkg::*;

	localparam int RAND_ITEMS = 1800;
	localparam int DIR_ROWS   = 21;
	localparam int HUE_STEP   = 960;
	localparam int HUE_WRAP   = 5760;
	localparam int BASE_RED   = 0;
	localparam int BASE_GREEN = 2 * HUE_STEP;
	localparam int BASE_BLUE  = 4 * HUE_STEP;
	localparam int MAX_GAP    = 14;
	localparam int SEG_LEN    = 128;
	localparam int HOLD_AT    = 600;
	localparam int HOLD_LEN   = 300;
	localparam int DRAIN_CYC  = 32;

	typedef struct packed {
		hue_t  hue;
		chan_t sat;
		chan_t val;
	} hsv_t;

	typedef struct packed {
		chan_t r;
		chan_t g;
		chan_t b;
		logic  known;
		hsv_t  want;
	} pixel_row_t;

	logic  clk = 1'b0;
	logic  arst_n;
	logic  rgb_valid;
	logic  rgb_stall;
	chan_t red;
	chan_t green;
	chan_t blue;
	logic  hsv_valid;
	logic  hsv_stall;
	hue_t  hue;
	chan_t saturation;
	chan_t value;

	hsv_t hsv_due[$];
	int   mismatches = 0;
	int   send_left  = 0;
	bit   send_quiet = 1'b0;

	rgb_to_hsv_converter_core uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.rgb_valid  (rgb_valid),
		.rgb_stall  (rgb_stall),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.hsv_valid  (hsv_valid),
		.hsv_stall  (hsv_stall),
		.hue        (hue),
		.saturation (saturation),
		.value      (value)
	);

	always #4 clk = ~clk;

	function automatic hsv_t hsv_of(input chan_t r, input chan_t g, input chan_t b);
		int   ri;
		int   gi;
		int   bi;
		int   mx;
		int   mn;
		int   delta;
		int   base;
		int   diff;
		int   h;
		hsv_t res;
		ri = int'(r);
		gi = int'(g);
		bi = int'(b);
		mx = ri;
		mn = ri;
		if (gi > mx) mx = gi;
		if (bi > mx) mx = bi;
		if (gi < mn) mn = gi;
		if (bi < mn) mn = bi;
		delta = mx - mn;
		res.val = chan_t'(mx);
		res.sat = '0;
		res.hue = '0;
		if (delta > 0) begin
			res.sat = chan_t'((delta * 255) / mx);
			if (ri == mx) begin
				base = BASE_RED;
				diff = gi - bi;
			end else if (gi == mx) begin
				base = BASE_GREEN;
				diff = bi - ri;
			end else begin
				base = BASE_BLUE;
				diff = ri - gi;
			end
			h = base + (HUE_STEP * diff) / delta;
			if (h < 0) h += HUE_WRAP;
			res.hue = hue_t'(h);
		end
		return res;
	endfunction

	// expected results typed in only for greys, primaries and simple ties
	function automatic pixel_row_t pixel_row(input int i);
		case (i)
			0:  return {8'd0,   8'd0,   8'd0,   1'b1, 13'd0,    8'd0,   8'd0};
			1:  return {8'd255, 8'd255, 8'd255, 1'b1, 13'd0,    8'd0,   8'd255};
			2:  return {8'd128, 8'd128, 8'd128, 1'b1, 13'd0,    8'd0,   8'd128};
			3:  return {8'd1,   8'd1,   8'd1,   1'b1, 13'd0,    8'd0,   8'd1};
			4:  return {8'd255, 8'd0,   8'd0,   1'b1, 13'd0,    8'd255, 8'd255};
			5:  return {8'd0,   8'd255, 8'd0,   1'b1, 13'd1920, 8'd255, 8'd255};
			6:  return {8'd0,   8'd0,   8'd255, 1'b1, 13'd3840, 8'd255, 8'd255};
			7:  return {8'd255, 8'd255, 8'd0,   1'b1, 13'd960,  8'd255, 8'd255};
			8:  return {8'd0,   8'd255, 8'd255, 1'b1, 13'd2880, 8'd255, 8'd255};
			9:  return {8'd255, 8'd0,   8'd255, 1'b1, 13'd4800, 8'd255, 8'd255};
			10: return {8'd1,   8'd0,   8'd0,   1'b1, 13'd0,    8'd255, 8'd1};
			11: return {8'd255, 8'd0,   8'd1,   1'b0, 29'd0};
			12: return {8'd255, 8'd254, 8'd254, 1'b0, 29'd0};
			13: return {8'd200, 8'd100, 8'd50,  1'b0, 29'd0};
			14: return {8'd50,  8'd200, 8'd100, 1'b0, 29'd0};
			15: return {8'd100, 8'd50,  8'd200, 1'b0, 29'd0};
			16: return {8'd0,   8'd1,   8'd0,   1'b0, 29'd0};
			17: return {8'd254, 8'd255, 8'd255, 1'b0, 29'd0};
			18: return {8'd0,   8'd0,   8'd1,   1'b0, 29'd0};
			19: return {8'd128, 8'd0,   8'd127, 1'b0, 29'd0};
			default: return {8'd255, 8'd128, 8'd255, 1'b0, 29'd0};
		endcase
	endfunction

	task automatic report_mismatch(input string what);
		$display("%0t ns: %s", $time, what);
		mismatches++;
	endtask

	task automatic offer_pixel(input chan_t r, input chan_t g, input chan_t b,
			input logic known, input hsv_t want);
		int gap;
		if (send_left == 0) begin
			send_quiet = ($urandom_range(0, 3) == 0);
			send_left  = SEG_LEN;
		end
		send_left--;
		gap = send_quiet ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			rgb_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rgb_valid <= 1'b1;
		red       <= r;
		green     <= g;
		blue      <= b;
		@(posedge clk);
		while (rgb_stall) @(posedge clk);
		hsv_due.push_back(known ? want : hsv_of(r, g, b));
	endtask

	initial begin : hsv_sink
		int   hold;
		int   left;
		int   taken;
		bit   quiet;
		hsv_t want;
		hsv_stall = 1'b0;
		left      = 0;
		taken     = 0;
		quiet     = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (left == 0) begin
				quiet = ($urandom_range(0, 3) == 0);
				left  = SEG_LEN;
			end
			left--;
			hold = quiet ? 0 : $urandom_range(0, MAX_GAP);
			// long hold-off so the pipeline fills and back-pressures the source
			if (taken == HOLD_AT) hold = HOLD_LEN;
			if (hold > 0) begin
				hsv_stall <= 1'b1;
				repeat (hold) @(posedge clk);
				hsv_stall <= 1'b0;
			end
			@(posedge clk);
			while (!hsv_valid) @(posedge clk);
			taken++;
			if (hsv_due.size() == 0) begin
				report_mismatch($sformatf("unexpected result hue %0d sat %0d val %0d",
					hue, saturation, value));
			end else begin
				want = hsv_due.pop_front();
				if (hue !== want.hue)
					report_mismatch($sformatf("hue got %0d want %0d", hue, want.hue));
				if (saturation !== want.sat)
					report_mismatch($sformatf("saturation got %0d want %0d",
						saturation, want.sat));
				if (value !== want.val)
					report_mismatch($sformatf("value got %0d want %0d", value, want.val));
			end
		end
	end

	initial begin : pixel_source
		pixel_row_t row;
		chan_t      r;
		chan_t      g;
		chan_t      b;
		chan_t      m;
		chan_t      lo;
		int         mode;
		int         pick;
		arst_n    = 1'b0;
		rgb_valid = 1'b0;
		red       = '0;
		green     = '0;
		blue      = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < DIR_ROWS; i++) begin
			row = pixel_row(i);
			offer_pixel(row.r, row.g, row.b, row.known, row.want);
		end

		for (int i = 0; i < RAND_ITEMS; i++) begin
			mode = $urandom_range(0, 9);
			case (mode)
				// grey
				0: begin
					r = chan_t'($urandom);
					g = r;
					b = r;
				end
				// two channels tied at the maximum
				1: begin
					m    = chan_t'($urandom_range(1, 255));
					lo   = chan_t'($urandom_range(0, int'(m) - 1));
					pick = $urandom_range(0, 2);
					r    = (pick == 1) ? lo : m;
					g    = (pick == 2) ? lo : m;
					b    = (pick == 0) ? lo : m;
				end
				// near grey, small delta
				2: begin
					r = chan_t'($urandom);
					g = r ^ chan_t'($urandom_range(0, 3));
					b = r ^ chan_t'($urandom_range(0, 3));
				end
				default: begin
					r = chan_t'($urandom);
					g = chan_t'($urandom);
					b = chan_t'($urandom);
				end
			endcase
			offer_pixel(r, g, b, 1'b0, '0);
		end
		rgb_valid <= 1'b0;

		while (hsv_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
		if (mismatches == 0)
			$display("rgb_to_hsv_converter_core: match");
		else
			$display("rgb_to_hsv_converter_core: mismatch");
		$finish;
	end

	initial begin : watchdog
		#4000000;
		$display("rgb_to_hsv_converter_core: mismatch");
		$finish;
	end

endmodule
